### rtl/tdfb_pkg.sv
// Shared types, constants, byte-packing functions and the CRC function of the telemetry frame builder.
package tdfb_pkg;

    localparam int NUM_SENSORS = 16;
    localparam int FRAME_LIMIT = 26;
    localparam int FIRST_ENTRY = 7;

    localparam logic [7:0] HDR_START = 8'h2F;
    localparam logic [7:0] KIND_DATA = 8'h40;
    localparam logic [7:0] CRC_POLY  = 8'h07;

    localparam logic [3:0] TYPE_6B   = 4'd0;
    localparam logic [3:0] TYPE_W14  = 4'd1;
    localparam logic [3:0] TYPE_W22  = 4'd4;
    localparam logic [3:0] TYPE_DT   = 4'd5;
    localparam logic [3:0] TYPE_W30  = 4'd8;
    localparam logic [3:0] TYPE_POS  = 4'd9;

    localparam logic [2:0] REG_MANUF = 3'd0;
    localparam logic [2:0] REG_DEV   = 3'd1;
    localparam logic [2:0] REG_MASK  = 3'd2;
    localparam logic [2:0] REG_TYPES = 3'd3;
    localparam logic [2:0] REG_PREC  = 3'd4;

    typedef struct packed {
        logic       store;
        logic       visit;
        logic       wr;
        logic [4:0] wr_idx;
        logic [2:0] pack_j;
        logic       emit;
        logic [4:0] emit_idx;
        logic [4:0] frame_n;
        logic       crc_clr;
    } t_cmd;

    typedef struct packed {
        logic       pick;
        logic [2:0] cnt;
        logic [2:0] vb;
        logic       out_free;
    } t_sts;

    function automatic logic [2:0] value_bytes(input logic [3:0] typ);
        logic [2:0] r;
        unique case (typ)
            TYPE_6B:  r = 3'd1;
            TYPE_W14: r = 3'd2;
            TYPE_W22: r = 3'd3;
            TYPE_DT:  r = 3'd3;
            TYPE_W30: r = 3'd4;
            TYPE_POS: r = 3'd4;
            default:  r = 3'd0;
        endcase
        return r;
    endfunction

    // value byte idx of a reading, low byte first
    function automatic logic [7:0] value_byte(input logic [3:0] typ, input logic [31:0] v,
                                              input logic [1:0] prec, input logic [1:0] idx);
        logic [7:0] sp;
        logic [7:0] b;
        logic [7:0] top;
        sp  = {v[31], prec, 5'b0};
        b   = v[8*idx +: 8];
        top = (b & 8'h1F) | sp;
        unique case (typ)
            TYPE_6B:  value_byte = top;
            TYPE_W14: value_byte = (idx == 2'd1) ? top : b;
            TYPE_W22: value_byte = (idx == 2'd2) ? top : b;
            TYPE_DT:  value_byte = (idx == 2'd2) ? (b | {v[31], 7'b0}) : b;
            TYPE_W30: value_byte = (idx == 2'd3) ? top : b;
            default:  value_byte = b;
        endcase
    endfunction

    function automatic logic [7:0] crc8(input logic [7:0] b, input logic [7:0] acc);
        logic [7:0] v;
        v = b ^ acc;
        for (int i = 0; i < 8; i++) begin
            v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
        end
        return v;
    endfunction

endpackage

### rtl/tdfb_dp.sv
// Datapath: configuration, sensor store, frame store, CRC and output register.
module tdfb_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [63:0]          i_cfg_data,
    input  logic [7:0]           i_sensor_id,
    input  logic [31:0]          i_sensor_value,
    input  logic                 i_stall,
    input  tdfb_pkg::t_cmd       i_cmd,
    output tdfb_pkg::t_sts       o_sts,
    output logic                 o_valid,
    output logic [7:0]           o_frame_byte,
    output logic                 o_last_byte
);
    logic [15:0] r_manuf, r_dev, r_mask, r_fresh;
    logic [63:0] r_types;
    logic [31:0] r_prec;
    logic [3:0]  r_ns;
    logic [31:0] r_vals [16];
    logic [7:0]  r_frame [32];
    logic [31:0] r_val;
    logic [3:0]  r_type;
    logic [1:0]  r_pr;
    logic        r_hi;
    logic [3:0]  r_kid;
    logic [7:0]  r_crc;
    logic        r_ovalid;
    logic [7:0]  r_obyte;
    logic        r_olast;

    logic [3:0]  cur_type;
    logic [2:0]  cur_vb;
    logic [3:0]  st_k;
    logic        st_ok;
    logic [7:0]  pack_b;
    logic [2:0]  vj;
    logic [7:0]  emit_b;
    logic [4:0]  n_m1;
    logic        e_body;

    assign cur_type = r_types[{r_ns, 2'b00} +: 4];
    assign cur_vb   = tdfb_pkg::value_bytes(cur_type);
    assign o_sts.pick     = r_fresh[r_ns] & r_mask[r_ns];
    assign o_sts.vb       = cur_vb;
    assign o_sts.cnt      = cur_vb + ((r_ns == 4'd15) ? 3'd2 : 3'd1);
    assign o_sts.out_free = !r_ovalid || !i_stall;

    assign st_k  = 4'(i_sensor_id - 8'd1);
    assign st_ok = (i_sensor_id >= 8'd1) && (i_sensor_id <= 8'(tdfb_pkg::NUM_SENSORS));

    // entry byte j: id/type (or type, id for sensor sixteen), then value bytes
    always_comb begin
        vj = i_cmd.pack_j - (r_hi ? 3'd2 : 3'd1);
        if (i_cmd.pack_j == 3'd0 && r_hi) begin
            pack_b = {4'h0, r_type};
        end else if (i_cmd.pack_j == 3'd0) begin
            pack_b = {r_kid, r_type};
        end else if (i_cmd.pack_j == 3'd1 && r_hi) begin
            pack_b = 8'h10;
        end else begin
            pack_b = tdfb_pkg::value_byte(r_type, r_val, r_pr, vj[1:0]);
        end
    end

    // entry bytes come from the frame store, everything else from here
    assign e_body = (i_cmd.emit_idx >= 5'(tdfb_pkg::FIRST_ENTRY)) &&
                    (i_cmd.emit_idx != i_cmd.frame_n);

    assign n_m1 = i_cmd.frame_n - 5'd1;
    always_comb begin
        if (i_cmd.emit_idx == 5'd0) begin
            emit_b = tdfb_pkg::HDR_START;
        end else if (i_cmd.emit_idx == 5'd1) begin
            emit_b = tdfb_pkg::KIND_DATA | {3'b000, n_m1};
        end else if (i_cmd.emit_idx == 5'd2) begin
            emit_b = r_manuf[7:0];
        end else if (i_cmd.emit_idx == 5'd3) begin
            emit_b = r_manuf[15:8];
        end else if (i_cmd.emit_idx == 5'd4) begin
            emit_b = r_dev[7:0];
        end else if (i_cmd.emit_idx == 5'd5) begin
            emit_b = r_dev[15:8];
        end else if (i_cmd.emit_idx == i_cmd.frame_n) begin
            emit_b = r_crc;
        end else begin
            emit_b = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_manuf  <= '0;
            r_dev    <= '0;
            r_mask   <= '0;
            r_types  <= '0;
            r_prec   <= '0;
            r_fresh  <= '0;
            r_ns     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tdfb_pkg::REG_MANUF: r_manuf <= i_cfg_data[15:0];
                    tdfb_pkg::REG_DEV:   r_dev   <= i_cfg_data[15:0];
                    tdfb_pkg::REG_MASK:  r_mask  <= i_cfg_data[15:0];
                    tdfb_pkg::REG_TYPES: r_types <= i_cfg_data;
                    tdfb_pkg::REG_PREC:  r_prec  <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
            if (i_cmd.store && st_ok) begin
                r_fresh[st_k] <= 1'b1;
            end
            if (i_cmd.visit) begin
                r_fresh[r_ns] <= 1'b0;
                r_ns <= (32'(r_ns) + 1 >= tdfb_pkg::NUM_SENSORS) ? 4'd0 : r_ns + 4'd1;
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store && st_ok) begin
            r_vals[st_k] <= i_sensor_value;
        end
        if (i_cmd.visit) begin
            r_val  <= r_vals[r_ns];
            r_type <= cur_type;
            r_pr   <= r_prec[{r_ns, 1'b0} +: 2];
            r_hi   <= (r_ns == 4'd15);
            r_kid  <= r_ns + 4'd1;
        end
        if (i_cmd.wr) begin
            r_frame[i_cmd.wr_idx] <= pack_b;
        end
        if (i_cmd.crc_clr) begin
            r_crc <= 8'h00;
        end else if (i_cmd.emit && e_body) begin
            r_crc <= tdfb_pkg::crc8(r_frame[i_cmd.emit_idx], r_crc);
        end else if (i_cmd.emit && i_cmd.emit_idx != 5'd0 && i_cmd.emit_idx != i_cmd.frame_n) begin
            r_crc <= tdfb_pkg::crc8(emit_b, r_crc);
        end
        if (i_cmd.emit) begin
            r_obyte <= e_body ? r_frame[i_cmd.emit_idx] : emit_b;
            r_olast <= (i_cmd.emit_idx == i_cmd.frame_n);
        end
    end

    assign o_valid      = r_ovalid;
    assign o_frame_byte = r_obyte;
    assign o_last_byte  = r_olast;
endmodule

### rtl/tdfb_ctrl.sv
// Controller: sequences store, sensor visits, packing and frame emission.
module tdfb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_op,
    input  tdfb_pkg::t_sts i_sts,
    output logic           o_stall,
    output tdfb_pkg::t_cmd o_cmd
);
    typedef enum logic [2:0] {S_IDLE, S_VISIT, S_PACK, S_NEXT, S_EMIT} t_state;

    t_state     r_state;
    logic [4:0] r_n;
    logic [4:0] r_e;
    logic [4:0] r_visits;
    logic [2:0] r_j;
    logic [2:0] r_cnt;
    logic [2:0] r_len;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        o_cmd          = '0;
        o_cmd.store    = (r_state == S_IDLE) && i_valid && !i_op;
        o_cmd.visit    = (r_state == S_VISIT);
        o_cmd.wr       = (r_state == S_PACK);
        o_cmd.wr_idx   = r_n;
        o_cmd.pack_j   = r_j;
        o_cmd.emit     = (r_state == S_EMIT) && i_sts.out_free;
        o_cmd.emit_idx = r_e;
        o_cmd.frame_n  = r_n;
        o_cmd.crc_clr  = (r_state == S_NEXT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_n      <= '0;
            r_e      <= '0;
            r_visits <= '0;
            r_j      <= '0;
            r_cnt    <= '0;
            r_len    <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && i_op) begin
                        r_n      <= 5'(tdfb_pkg::FIRST_ENTRY);
                        r_visits <= '0;
                        r_state  <= S_VISIT;
                    end
                end
                S_VISIT: begin
                    r_j      <= '0;
                    r_cnt    <= i_sts.cnt;
                    r_visits <= r_visits + 5'd1;
                    if (i_sts.pick) begin
                        r_len   <= i_sts.vb + 3'd1;
                        r_state <= S_PACK;
                    end else begin
                        r_len   <= '0;
                        r_state <= S_NEXT;
                    end
                end
                S_PACK: begin
                    r_n <= r_n + 5'd1;
                    r_j <= r_j + 3'd1;
                    if (r_j == r_cnt - 3'd1) begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    r_e <= '0;
                    if (32'(r_visits) >= tdfb_pkg::NUM_SENSORS ||
                        32'(r_n) + 32'(r_len) >= tdfb_pkg::FRAME_LIMIT) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_VISIT;
                    end
                end
                S_EMIT: begin
                    if (i_sts.out_free) begin
                        r_e <= r_e + 5'd1;
                        if (r_e == r_n) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/telemetry_data_frame_builder_top.sv
// Top level of the telemetry data-frame builder.
// Operation: a store word is taken while idle; a build walks up to sixteen sensors, visiting
// each and packing its bytes, then emits n+1 words at one per cycle while the receiver does not stall.
// Throughput: one item at a time; the input is stalled while a build runs, paced
// by the visit/pack sequencer and the single frame-store write port.
// Reset (synchronous, active low) clears configuration, fresh flags and the sensor pointer.
module telemetry_data_frame_builder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [7:0]  i_sensor_id,
    input  logic signed [31:0] i_sensor_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_frame_byte,
    output logic        o_last_byte,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);
    tdfb_pkg::t_cmd cmd;
    tdfb_pkg::t_sts sts;

    // sequence the build: visit, pack, decide, emit
    tdfb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .i_sts   (sts),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    // hold the sensor store, frame store, CRC and output word
    tdfb_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_sensor_id    (i_sensor_id),
        .i_sensor_value (32'(i_sensor_value)),
        .i_stall        (i_stall),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_valid        (o_valid),
        .o_frame_byte   (o_frame_byte),
        .o_last_byte    (o_last_byte)
    );

`ifndef SYNTHESIS
    // a frame ends only once all its words are queued, so the input stays stalled until then
    a_stall_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_byte |-> o_stall)
        else $error("input not stalled mid-frame");

    // no word follows the closing CRC word straight away
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_byte && !i_stall |=> !o_valid)
        else $error("word right after frame end");
`endif
endmodule

### test/telemetry_data_frame_builder_top_test.sv
// Self-checking testbench of the telemetry data-frame builder: predicted frames against emitted words.
module telemetry_data_frame_builder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Frame predictor and the queue of expected frame words.
    class frame_board;
        logic [15:0] manuf, dev, mask, fresh;
        logic [63:0] types;
        logic [31:0] precs;
        logic [31:0] readings [16];
        logic [3:0]  cursor;
        logic [8:0]  pending [$];
        int          errors;
        int          frames;

        function new();
            manuf = 0; dev = 0; mask = 0; fresh = 0; types = 0; precs = 0;
            cursor = 0; errors = 0; frames = 0;
            foreach (readings[k]) readings[k] = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [63:0] d);
            case (idx)
                tdfb_pkg::REG_MANUF: manuf = d[15:0];
                tdfb_pkg::REG_DEV:   dev   = d[15:0];
                tdfb_pkg::REG_MASK:  mask  = d[15:0];
                tdfb_pkg::REG_TYPES: types = d;
                tdfb_pkg::REG_PREC:  precs = d[31:0];
                default: ;
            endcase
        endfunction

        // Note an accepted input word; a build predicts the whole frame.
        function void note_word(logic op, logic [7:0] id, logic [31:0] val);
            logic [7:0] fb [32];
            logic [31:0] v;
            logic [7:0] sp, crc;
            int n, len, visits, k, vb;
            logic [3:0] ty;
            if (op == 1'b0) begin
                if (id >= 1 && id <= tdfb_pkg::NUM_SENSORS) begin
                    readings[id-1] = val;
                    fresh[id-1] = 1'b1;
                end
                return;
            end
            n = tdfb_pkg::FIRST_ENTRY; visits = 0;
            forever begin
                k = cursor;
                ty = types[4*k +: 4];
                len = 0;
                if (fresh[k] && mask[k]) begin
                    if (k + 1 > 15) begin
                        fb[n] = {4'd0, ty}; fb[n+1] = 8'(k + 1); n += 2;
                    end else begin
                        fb[n] = {4'(k + 1), ty}; n += 1;
                    end
                    v = readings[k];
                    sp = {v[31], precs[2*k +: 2], 5'b0};
                    vb = 0;
                    case (ty)
                        tdfb_pkg::TYPE_6B: begin fb[n] = (v[7:0] & 8'h1F) | sp; vb = 1; end
                        tdfb_pkg::TYPE_W14: begin
                            fb[n] = v[7:0]; fb[n+1] = (v[15:8] & 8'h1F) | sp; vb = 2;
                        end
                        tdfb_pkg::TYPE_W22: begin
                            fb[n] = v[7:0]; fb[n+1] = v[15:8];
                            fb[n+2] = (v[23:16] & 8'h1F) | sp; vb = 3;
                        end
                        tdfb_pkg::TYPE_DT: begin
                            fb[n] = v[7:0]; fb[n+1] = v[15:8];
                            fb[n+2] = v[23:16] | {v[31], 7'b0}; vb = 3;
                        end
                        tdfb_pkg::TYPE_W30: begin
                            fb[n] = v[7:0]; fb[n+1] = v[15:8]; fb[n+2] = v[23:16];
                            fb[n+3] = (v[31:24] & 8'h1F) | sp; vb = 4;
                        end
                        tdfb_pkg::TYPE_POS: begin
                            fb[n] = v[7:0]; fb[n+1] = v[15:8]; fb[n+2] = v[23:16];
                            fb[n+3] = v[31:24]; vb = 4;
                        end
                        default: vb = 0;
                    endcase
                    n += vb;
                    len = vb + 1;
                end
                fresh[k] = 1'b0;
                cursor = (k + 1 >= tdfb_pkg::NUM_SENSORS) ? 4'd0 : 4'(k + 1);
                visits++;
                if (visits >= tdfb_pkg::NUM_SENSORS) break;
                if (n + len >= tdfb_pkg::FRAME_LIMIT) break;
            end
            fb[0] = tdfb_pkg::HDR_START;
            fb[1] = tdfb_pkg::KIND_DATA | 8'((n - 1) & 8'h3F);
            fb[2] = manuf[7:0]; fb[3] = manuf[15:8];
            fb[4] = dev[7:0];   fb[5] = dev[15:8];
            fb[6] = 8'h00;
            crc = 0;
            for (int i = 1; i < n; i++) begin
                v = {24'd0, fb[i] ^ crc};
                for (int b = 0; b < 8; b++)
                    v[7:0] = v[7] ? ({v[6:0], 1'b0} ^ 8'h07) : {v[6:0], 1'b0};
                crc = v[7:0];
            end
            fb[n] = crc;
            for (int i = 0; i <= n; i++) pending.push_back({(i == n), fb[i]});
            frames++;
        endfunction

        function void check_word(logic [7:0] b, logic last);
            logic [8:0] e;
            if (pending.size() == 0) begin
                $error("unexpected frame word %h last %b", b, last);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (b !== e[7:0]) begin
                $error("frame_byte expected %h actual %h", e[7:0], b);
                errors++;
            end
            if (last !== e[8]) begin
                $error("last_byte expected %b actual %b", e[8], last);
                errors++;
            end
        endfunction
    endclass

    logic        clk, rst_n;
    logic        in_valid, out_valid, out_stall;
    logic        op;
    logic [7:0]  sid;
    logic signed [31:0] sval;
    logic [7:0]  fbyte;
    logic        flast;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [63:0] cfg_data;
    logic        dut_stall;
    logic        quiet;      // no idling in the closing part of the run
    int          idle_cnt;
    int          watchdog;
    frame_board  board;

    telemetry_data_frame_builder_top dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(dut_stall),
        .i_op(op), .i_sensor_id(sid), .i_sensor_value(sval),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_frame_byte(fbyte), .o_last_byte(flast),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    initial begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial begin
        in_valid = 0; op = 0; sid = 0; sval = 0; out_stall = 0;
        cfg_we = 0; cfg_idx = tdfb_pkg::REG_MANUF; cfg_data = 0; rst_n = 0;
        quiet = 0; watchdog = 0; idle_cnt = 0;
    end

    // Check every accepted output word; drive receiver stall in bursts.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) board.check_word(fbyte, flast);
            if (idle_cnt > 0) begin
                idle_cnt <= idle_cnt - 1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                idle_cnt <= $urandom_range(1, 12);
            end else begin
                out_stall <= 1'b0;
            end
            // watchdog: count cycles with no accepted word on either side
            if ((out_valid && !out_stall) || (in_valid && !dut_stall) || cfg_we)
                watchdog <= 0;
            else
                watchdog <= watchdog + 1;
            if (watchdog > 5000) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] d);
        cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_reg(idx, d);
    endtask

    // Present one word, hold it until taken, with optional idle gap first.
    task automatic send_word(input logic o, input logic [7:0] id, input logic [31:0] v);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1; op <= o; sid <= id; sval <= v;
        @(posedge clk);
        while (dut_stall) @(posedge clk);
        board.note_word(o, id, v);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic store_rand(input int lo, input int hi);
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 3))
            0: v = 32'h8000_0000 | ($urandom & 32'hFF);
            1: v = 32'h7FFF_FFFF;
            default: ;
        endcase
        send_word(1'b0, 8'($urandom_range(lo, hi)), v);
    endtask

    task automatic random_config(input bit extreme);
        write_reg(tdfb_pkg::REG_MANUF, extreme ? 64'hFFFF : 64'($urandom_range(0, 65535)));
        write_reg(tdfb_pkg::REG_DEV,   extreme ? 64'hFFFF : 64'($urandom_range(0, 65535)));
        write_reg(tdfb_pkg::REG_MASK,
                  extreme ? 64'hFFFF : 64'($urandom_range(0, 65535) | 16'h8001));
        write_reg(tdfb_pkg::REG_TYPES, extreme ? 64'h9898_9898_9898_9898 : {$urandom, $urandom});
        write_reg(tdfb_pkg::REG_PREC,  extreme ? 64'hFFFF_FFFF : 64'($urandom));
    endtask

    initial begin
        int sent;
        board = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Build with nothing fresh and all-zero configuration.
        send_word(1'b1, 8'd0, 32'd0);
        drain();
        write_reg(tdfb_pkg::REG_MANUF, 64'h1234);
        write_reg(tdfb_pkg::REG_DEV, 64'hABCD);
        write_reg(tdfb_pkg::REG_MASK, 64'hFFFF);
        write_reg(tdfb_pkg::REG_TYPES, 64'hF908_5410_9854_1072);  // every type, unknown codes too
        write_reg(tdfb_pkg::REG_PREC, 64'hE4E4_E4E4);
        // Out-of-range ids are dropped; extremes of the reading.
        send_word(1'b0, 8'd0, 32'h1111_1111);
        send_word(1'b0, 8'd17, 32'h2222_2222);
        send_word(1'b0, 8'd255, 32'hFFFF_FFFF);
        send_word(1'b0, 8'd1, 32'h8000_0000);
        send_word(1'b0, 8'd2, 32'h7FFF_FFFF);
        send_word(1'b0, 8'd3, 32'hFFFF_FFFF);
        send_word(1'b0, 8'd4, 32'h0000_0000);
        send_word(1'b0, 8'd5, 32'hA5A5_5A5A);
        send_word(1'b0, 8'd15, 32'h8123_4567);
        send_word(1'b0, 8'd16, 32'hDEAD_BEEF);
        send_word(1'b1, 8'd0, 32'd0);
        for (int i = 1; i <= 16; i++) send_word(1'b0, 8'(i), $urandom);
        send_word(1'b1, 8'hFF, 32'hFFFF_FFFF);  // hits the frame limit
        send_word(1'b1, 8'd0, 32'd0);
        drain();

        // Random phases, each under a fresh configuration.
        sent = 0;
        for (int ph = 0; sent < 224; ph++) begin
            random_config(ph == 1);
            if (ph == 2) write_reg(tdfb_pkg::REG_MASK, 64'h0);
            if (ph >= 5) quiet = 1;
            for (int j = 0; j < 32; j++) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_word(1'b1, 8'($urandom), $urandom);
                end else if ($urandom_range(0, 9) == 0) begin
                    store_rand(17, 255);
                end else begin
                    store_rand(1, 16);
                end
                sent++;
            end
            send_word(1'b1, 8'd0, 32'd0);
            drain();
        end

        $display("covered %0d frames over %0d random words, all registers, all type codes",
                 board.frames, sent);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
